FILE: rtl/nvs_pkg.sv
// ----------------------------------------------------------------------------
// nvs_pkg
// shared types and constants of the nearest vector search block
// ----------------------------------------------------------------------------
package nvs_pkg;

   localparam logic [1:0] OP_BUILD = 2'd0;
   localparam logic [1:0] OP_ADD   = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;
   localparam logic [1:0] OP_NONE  = 2'd3;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_EMPTY    = 2'd1;
   localparam logic [1:0] ST_DIM_ERR  = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   localparam logic CSR_VECTOR_LENGTH = 1'b0;
   localparam logic CSR_TOP_K         = 1'b1;

   // commands from controller to datapath
   typedef struct packed {
      logic clr_best;   // reset ranking list
      logic acc_clr;    // clear distance accumulator
      logic acc_en;     // accumulate one product
      logic insert;     // rank finished distance
   } dp_cmd_type;

endpackage

FILE: rtl/nvs_ctrl.sv
// ----------------------------------------------------------------------------
// nvs_ctrl
// search sequencer: walks entries and elements, then emits ranked words
// ----------------------------------------------------------------------------
module nvs_ctrl #(
   parameter int ENT_W = 8,
   parameter int DIM_W = 7,
   parameter int K_W   = 3
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             go,
   input  logic [ENT_W:0]   n_entries,
   input  logic [DIM_W:0]   n_dim,
   input  logic [K_W:0]     n_out,
   output logic             busy,
   output logic [ENT_W-1:0] rd_entry,
   output logic [DIM_W-1:0] rd_elem,
   output logic             emit,
   output logic [K_W-1:0]   emit_rank,
   output logic             emit_last,
   output nvs_pkg::dp_cmd_type cmd
);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_READ  = 5'b00010,
      S_DRAIN = 5'b00100,
      S_INS   = 5'b01000,
      S_OUT   = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic [ENT_W:0]   ent_ff, ent_in;
   logic [DIM_W:0]   elem_ff, elem_in;
   logic [1:0]       drain_ff, drain_in;
   logic [K_W:0]     rk_ff, rk_in;
   logic             v1_ff, v2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ent_ff   <= '0;
         elem_ff  <= '0;
         drain_ff <= '0;
         rk_ff    <= '0;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         ent_ff   <= ent_in;
         elem_ff  <= elem_in;
         drain_ff <= drain_in;
         rk_ff    <= rk_in;
         v1_ff    <= (state_ff == S_READ);
         v2_ff    <= v1_ff;
      end
   end

   // memory read register, then product register, then accumulate
   always_comb begin
      state_in = state_ff;
      ent_in   = ent_ff;
      elem_in  = elem_ff;
      drain_in = drain_ff;
      rk_in    = rk_ff;
      cmd      = '0;
      cmd.acc_en = v2_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (go) begin
               state_in     = S_READ;
               ent_in       = '0;
               elem_in      = '0;
               cmd.clr_best = 1'b1;
               cmd.acc_clr  = 1'b1;
            end
         end
         S_READ: begin
            if (elem_ff + 1'b1 == n_dim) begin
               state_in = S_DRAIN;
               drain_in = 2'd0;
            end else begin
               elem_in = elem_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            drain_in = drain_ff + 2'd1;
            if (drain_ff == 2'd1) state_in = S_INS;
         end
         S_INS: begin
            cmd.insert  = 1'b1;
            cmd.acc_clr = 1'b1;
            elem_in     = '0;
            if (ent_ff + 1'b1 == n_entries) begin
               state_in = S_OUT;
               rk_in    = '0;
            end else begin
               ent_in   = ent_ff + 1'b1;
               state_in = S_READ;
            end
         end
         S_OUT: begin
            rk_in = rk_ff + 1'b1;
            if (rk_ff + 1'b1 == n_out) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign busy      = (state_ff != S_IDLE);
   assign rd_entry  = ent_ff[ENT_W-1:0];
   assign rd_elem   = elem_ff[DIM_W-1:0];
   assign emit      = (state_ff == S_OUT);
   assign emit_rank = rk_ff[K_W-1:0];
   assign emit_last = (rk_ff + 1'b1 == n_out);

endmodule

FILE: rtl/nvs_datapath.sv
// ----------------------------------------------------------------------------
// nvs_datapath
// vector, label and query memories, distance accumulator and ranking list
// ----------------------------------------------------------------------------
module nvs_datapath #(
   parameter int ENT_W = 8,
   parameter int DIM_W = 7,
   parameter int K_MAX = 8,
   parameter int K_W   = 3,
   parameter int ACC_W = 41
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             vec_we,
   input  logic [ENT_W-1:0] vec_wr_entry,
   input  logic             qry_we,
   input  logic [DIM_W-1:0] wr_elem,
   input  logic [15:0]      wr_data,
   input  logic             lab_we,
   input  logic [15:0]      lab_data,
   input  logic [ENT_W-1:0] rd_entry,
   input  logic [DIM_W-1:0] rd_elem,
   input  logic [K_W:0]     k_eff,
   input  nvs_pkg::dp_cmd_type cmd,
   input  logic [K_W-1:0]   out_rank,
   output logic [15:0]      out_label,
   output logic [15:0]      out_sim
);

   localparam int DEPTH = (1 << ENT_W) * (1 << DIM_W);

   logic [15:0] vec_mem [DEPTH];
   logic [15:0] qry_mem [1 << DIM_W];
   logic [15:0] lab_mem [1 << ENT_W];

   logic [15:0] vec_rd_ff, qry_rd_ff;
   logic [33:0] prod_ff;
   logic [ACC_W-1:0] acc_ff;
   logic [ENT_W-1:0] ent_d1_ff, ent_d2_ff, cur_ent_ff;
   logic [ACC_W-1:0] bd_ff [K_MAX];
   logic [ENT_W-1:0] bi_ff [K_MAX];
   logic [ACC_W-1:0] bd_in [K_MAX];
   logic [ENT_W-1:0] bi_in [K_MAX];

   always_ff @(posedge clock) begin
      if (vec_we) vec_mem[{vec_wr_entry, wr_elem}] <= wr_data;
      vec_rd_ff <= vec_mem[{rd_entry, rd_elem}];
   end

   always_ff @(posedge clock) begin
      if (qry_we) qry_mem[wr_elem] <= wr_data;
      qry_rd_ff <= qry_mem[rd_elem];
   end

   always_ff @(posedge clock) begin
      if (lab_we) lab_mem[vec_wr_entry] <= lab_data;
      out_label <= lab_mem[bi_ff[out_rank]];
   end

   logic signed [16:0] diff;
   assign diff = $signed({qry_rd_ff[15], qry_rd_ff}) - $signed({vec_rd_ff[15], vec_rd_ff});

   always_ff @(posedge clock) begin
      prod_ff   <= 34'(diff * diff);
      ent_d1_ff <= rd_entry;
      ent_d2_ff <= ent_d1_ff;
      if (cmd.acc_clr)      acc_ff <= '0;
      else if (cmd.acc_en) begin
         acc_ff     <= acc_ff + ACC_W'(prod_ff);
         cur_ent_ff <= ent_d2_ff;
      end
   end

   // insertion into the sorted list, strict compare keeps earlier entries
   always_comb begin
      logic [K_MAX-1:0] lt;
      logic prev_lt;
      int im1;
      for (int i = 0; i < K_MAX; i++) lt[i] = (acc_ff < bd_ff[i]) && (K_W+1)'(i) < k_eff;
      prev_lt = 1'b0;
      for (int i = 0; i < K_MAX; i++) begin
         im1 = (i > 0) ? i - 1 : 0;
         bd_in[i] = bd_ff[i];
         bi_in[i] = bi_ff[i];
         if (lt[i]) begin
            if (!prev_lt) begin
               bd_in[i] = acc_ff;
               bi_in[i] = cur_ent_ff;
            end else begin
               bd_in[i] = bd_ff[im1];
               bi_in[i] = bi_ff[im1];
            end
         end
         prev_lt = lt[i];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < K_MAX; i++) begin
         if (reset || cmd.clr_best) begin
            bd_ff[i] <= '1;
            bi_ff[i] <= '0;
         end else if (cmd.insert) begin
            bd_ff[i] <= bd_in[i];
            bi_ff[i] <= bi_in[i];
         end
      end
   end

   logic [ACC_W-1:0] qv;
   always_comb begin
      qv = (bd_ff[out_rank] + ACC_W'(65536)) >> 17;
   end
   always_ff @(posedge clock) begin
      out_sim <= (qv >= ACC_W'(32768)) ? 16'd0 : 16'(ACC_W'(32768) - qv);
   end

endmodule

FILE: rtl/nearest_vector_search.sv
// ----------------------------------------------------------------------------
// nearest_vector_search
// exhaustive squared-L2 nearest neighbor search over a table of vectors
// ----------------------------------------------------------------------------
// The last word of a query starts a walk of every entry through the single
// vector memory read port, then min(top_k clamped to 1..K_MAX, entry_count)
// ranked words leave one per cycle, each in the cycle after its slot is read.
// Add and build answers and errors come in the cycle after the word. busy is
// high during the walk and output; rsp_valid words cannot be held off.
module nearest_vector_search #(
   parameter int MAX_ENTRIES = 256,
   parameter int MAX_DIM     = 128,
   parameter int K_MAX       = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_op,
   input  logic signed [15:0] req_element_value,
   input  logic [15:0] req_label_id,
   input  logic        req_last_element,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [2:0]  rsp_rank,
   output logic [15:0] rsp_match_label,
   output logic [15:0] rsp_similarity,
   output logic        rsp_last_result,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [7:0]  csr_data
);

   localparam int ENT_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int DIM_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int K_W   = (K_MAX > 1) ? $clog2(K_MAX) : 1;
   localparam int ACC_W = 34 + DIM_W;

   logic [7:0]       vlen_ff;
   logic [3:0]       topk_ff;
   logic [ENT_W:0]   count_ff;
   logic             built_ff;
   logic [DIM_W+1:0] ecnt_ff;
   logic             ctl_busy;
   logic             go;
   logic             emit, emit_last, emit_d_ff, emit_last_d_ff;
   logic [K_W-1:0]   emit_rank, rank_d_ff;
   logic [ENT_W-1:0] rd_entry;
   logic [DIM_W-1:0] rd_elem;
   logic [15:0]      out_label, out_sim;
   nvs_pkg::dp_cmd_type cmd;

   logic        simple_ff;
   logic [1:0]  sstat_ff;

   logic acc, elem_op, closing, dim_ok, in_range;
   logic [DIM_W+1:0] cnt_new;
   logic [K_W:0]     k_eff, n_out;

   assign acc      = start && !busy;
   assign elem_op  = acc && (req_op == nvs_pkg::OP_ADD || req_op == nvs_pkg::OP_QUERY);
   assign in_range = ecnt_ff < (DIM_W+2)'(MAX_DIM);
   assign cnt_new  = (ecnt_ff <= (DIM_W+2)'(MAX_DIM)) ? ecnt_ff + 1'b1 : ecnt_ff;
   assign closing  = elem_op && req_last_element;
   assign dim_ok   = (32'(cnt_new) == 32'(vlen_ff)) && (32'(vlen_ff) <= MAX_DIM);
   assign k_eff    = (topk_ff == 4'd0) ? (K_W+1)'(1) :
                     (32'(topk_ff) > K_MAX) ? (K_W+1)'(K_MAX) : (K_W+1)'(topk_ff);
   assign n_out    = (32'(count_ff) < 32'(k_eff)) ? (K_W+1)'(count_ff) : k_eff;
   assign go       = closing && req_op == nvs_pkg::OP_QUERY && built_ff &&
                     count_ff != '0 && dim_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         vlen_ff <= 8'd128;
         topk_ff <= 4'd1;
      end else if (csr_we) begin
         unique case (csr_index)
            nvs_pkg::CSR_VECTOR_LENGTH: vlen_ff <= csr_data;
            nvs_pkg::CSR_TOP_K:         topk_ff <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         built_ff  <= 1'b0;
         ecnt_ff   <= '0;
         simple_ff <= 1'b0;
         sstat_ff  <= nvs_pkg::ST_OK;
      end else begin
         simple_ff <= 1'b0;
         if (acc && req_op == nvs_pkg::OP_BUILD) begin
            built_ff  <= 1'b1;
            count_ff  <= '0;
            ecnt_ff   <= '0;
            simple_ff <= 1'b1;
            sstat_ff  <= nvs_pkg::ST_OK;
         end else if (elem_op) begin
            ecnt_ff <= req_last_element ? '0 : cnt_new;
            if (closing && !go) begin
               simple_ff <= 1'b1;
               if (req_op == nvs_pkg::OP_ADD) begin
                  priority if (!built_ff)      sstat_ff <= nvs_pkg::ST_EMPTY;
                  else if (!dim_ok)            sstat_ff <= nvs_pkg::ST_DIM_ERR;
                  else if (32'(count_ff) >= MAX_ENTRIES) sstat_ff <= nvs_pkg::ST_FULL;
                  else begin
                     sstat_ff <= nvs_pkg::ST_OK;
                     count_ff <= count_ff + 1'b1;
                  end
               end else begin
                  priority if (!built_ff || count_ff == '0) sstat_ff <= nvs_pkg::ST_EMPTY;
                  else                                      sstat_ff <= nvs_pkg::ST_DIM_ERR;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         emit_d_ff      <= 1'b0;
         emit_last_d_ff <= 1'b0;
         rank_d_ff      <= '0;
      end else begin
         emit_d_ff      <= emit;
         emit_last_d_ff <= emit_last;
         rank_d_ff      <= emit_rank;
      end
   end

   nvs_ctrl #(.ENT_W(ENT_W), .DIM_W(DIM_W), .K_W(K_W)) u_ctrl (
      .clock, .reset, .go,
      .n_entries (count_ff), .n_dim (DIM_W'(vlen_ff - 8'd1) + (DIM_W+1)'(1)),
      .n_out, .busy (ctl_busy), .rd_entry, .rd_elem,
      .emit, .emit_rank, .emit_last, .cmd
   );

   nvs_datapath #(.ENT_W(ENT_W), .DIM_W(DIM_W), .K_MAX(K_MAX), .K_W(K_W),
                  .ACC_W(ACC_W)) u_dp (
      .clock, .reset,
      .vec_we (elem_op && req_op == nvs_pkg::OP_ADD && in_range &&
               32'(count_ff) < MAX_ENTRIES),
      .vec_wr_entry (count_ff[ENT_W-1:0]),
      .qry_we (elem_op && req_op == nvs_pkg::OP_QUERY && in_range),
      .wr_elem (ecnt_ff[DIM_W-1:0]),
      .wr_data (req_element_value),
      .lab_we (closing && req_op == nvs_pkg::OP_ADD && built_ff && dim_ok &&
               32'(count_ff) < MAX_ENTRIES),
      .lab_data (req_label_id),
      .rd_entry, .rd_elem, .k_eff, .cmd,
      .out_rank (emit_rank), .out_label, .out_sim
   );

   assign busy            = ctl_busy || emit_d_ff;
   assign rsp_valid       = simple_ff || emit_d_ff;
   assign rsp_status      = emit_d_ff ? nvs_pkg::ST_OK : sstat_ff;
   assign rsp_rank        = emit_d_ff ? 3'(rank_d_ff) : 3'd0;
   assign rsp_match_label = emit_d_ff ? out_label : 16'd0;
   assign rsp_similarity  = emit_d_ff ? out_sim : 16'd0;
   assign rsp_last_result = emit_d_ff ? emit_last_d_ff : 1'b1;

   a_one_src: assert property (@(posedge clock) disable iff (reset)
      !(simple_ff && emit_d_ff)) else $error("two result sources at once");
   a_go_idle: assert property (@(posedge clock) disable iff (reset)
      go |=> ctl_busy) else $error("search did not start");
   a_busy_noacc: assert property (@(posedge clock) disable iff (reset)
      emit_d_ff |-> busy) else $error("accept during output");

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for nearest_vector_search: element words are driven
// through the start/busy handshake while a behavioral search table predicts
// the ranked match and status words, which are compared against the rsp strobe stream
// ----------------------------------------------------------------------------
module tb;

   localparam int N_ENT = 256;
   localparam int N_DIM = 128;
   localparam int N_K   = 8;
   localparam int N_ROWS = 16;
   localparam int CYCLE_LIMIT = 3000000;

   typedef struct packed {
      logic [1:0]  status;
      logic [2:0]  rank;
      logic [15:0] label;
      logic [15:0] sim;
      logic        last;
   } match_word_type;

   typedef struct {
      logic [1:0]  op;
      int          len;
      int          count;
      logic [15:0] value;
      logic [15:0] label;
      bit          typed;
      logic [1:0]  status;
      logic [15:0] exp_label;
      logic [15:0] exp_sim;
   } vector_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_op = nvs_pkg::OP_BUILD;
   logic signed [15:0] req_element_value = '0;
   logic [15:0] req_label_id = '0;
   logic        req_last_element = 1'b0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [2:0]  rsp_rank;
   logic [15:0] rsp_match_label;
   logic [15:0] rsp_similarity;
   logic        rsp_last_result;
   logic        csr_we = 1'b0;
   logic        csr_index = nvs_pkg::CSR_VECTOR_LENGTH;
   logic [7:0]  csr_data = '0;

   nearest_vector_search uut (.*);

   always #10 clock = ~clock;

   // search table mirror
   logic [15:0] table_vec [N_ENT][N_DIM];
   logic [15:0] table_label [N_ENT];
   logic [15:0] query_vec [N_DIM];
   int          n_entries = 0;
   int          elem_count = 0;
   bit          table_ready = 0;
   int          vec_len = 128;
   int          top_k = 1;

   match_word_type expected_matches [$];
   match_word_type fresh [$];
   int          mismatches = 0;
   int          idle_pct = 0;
   longint      cycles = 0;

   function automatic logic [15:0] to_sim(longint unsigned d2);
      longint unsigned q;
      q = (d2 + 65536) >> 17;
      return q >= 32768 ? 16'd0 : 16'(32768 - q);
   endfunction

   function automatic void push_one(logic [1:0] st);
      match_word_type w;
      w = '{st, 3'd0, 16'd0, 16'd0, 1'b1};
      fresh = {fresh, w};
   endfunction

   // rank the table against the query buffer, ties keep the earlier entry
   function automatic void rank_matches();
      longint unsigned best_d [N_K];
      int best_i [N_K];
      int k, nbest, pos, j;
      longint unsigned d;
      int diff;
      match_word_type w;
      k = top_k == 0 ? 1 : (top_k > N_K ? N_K : top_k);
      nbest = 0;
      for (int i = 0; i < n_entries; i++) begin
         d = 0;
         for (int e = 0; e < vec_len && e < N_DIM; e++) begin
            diff = int'($signed(query_vec[e])) - int'($signed(table_vec[i][e]));
            d += longint'(diff) * longint'(diff);
         end
         pos = nbest;
         while (pos > 0 && d < best_d[pos-1]) pos--;
         if (pos < k) begin
            j = nbest < k ? nbest : k - 1;
            for (; j > pos; j--) begin
               best_d[j] = best_d[j-1];
               best_i[j] = best_i[j-1];
            end
            best_d[pos] = d;
            best_i[pos] = i;
            if (nbest < k) nbest++;
         end
      end
      for (int i = 0; i < nbest; i++) begin
         w = '{nvs_pkg::ST_OK, 3'(i), table_label[best_i[i]], to_sim(best_d[i]),
               1'(i + 1 == nbest)};
         fresh = {fresh, w};
      end
   endfunction

   function automatic void predict_word(logic [1:0] op, logic [15:0] val,
                                        logic [15:0] lab, logic lst);
      int cnt;
      bit dim_ok;
      fresh.delete();
      if (op == nvs_pkg::OP_BUILD) begin
         table_ready = 1;
         n_entries = 0;
         elem_count = 0;
         push_one(nvs_pkg::ST_OK);
         return;
      end
      if (op == nvs_pkg::OP_NONE) return;
      if (elem_count < N_DIM) begin
         if (op == nvs_pkg::OP_ADD) begin
            if (n_entries < N_ENT) table_vec[n_entries][elem_count] = val;
         end else begin
            query_vec[elem_count] = val;
         end
      end
      if (elem_count <= N_DIM) elem_count++;
      if (!lst) return;
      cnt = elem_count;
      elem_count = 0;
      dim_ok = cnt == vec_len && vec_len <= N_DIM;
      if (op == nvs_pkg::OP_ADD) begin
         if (!table_ready) push_one(nvs_pkg::ST_EMPTY);
         else if (!dim_ok) push_one(nvs_pkg::ST_DIM_ERR);
         else if (n_entries >= N_ENT) push_one(nvs_pkg::ST_FULL);
         else begin
            table_label[n_entries] = lab;
            n_entries++;
            push_one(nvs_pkg::ST_OK);
         end
      end else if (!table_ready || n_entries == 0) push_one(nvs_pkg::ST_EMPTY);
      else if (!dim_ok) push_one(nvs_pkg::ST_DIM_ERR);
      else rank_matches();
   endfunction

   // returns at the accepting edge
   task automatic send_word(logic [1:0] op, logic [15:0] val, logic [15:0] lab,
                            logic lst, bit typed = 0, match_word_type tw = '0);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_op <= op;
      req_element_value <= val;
      req_label_id <= lab;
      req_last_element <= lst;
      do @(posedge clock); while (busy);
      predict_word(op, val, lab, lst);
      if (typed && lst) expected_matches = {expected_matches, tw};
      else expected_matches = {expected_matches, fresh};
   endtask

   task automatic quiesce();
      start <= 1'b0;
      do @(posedge clock); while (expected_matches.size() != 0 || busy);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [7:0] val);
      quiesce();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == nvs_pkg::CSR_VECTOR_LENGTH) vec_len = val;
      else top_k = val[3:0];
   endtask

   function automatic logic [15:0] rand_elem();
      case ($urandom_range(5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_vector(logic [1:0] op, int n, logic [15:0] lab, int copy_of = -1);
      logic [15:0] v;
      for (int e = 0; e < n; e++) begin
         v = copy_of >= 0 && e < N_DIM ? table_vec[copy_of][e] : rand_elem();
         if (copy_of >= 0 && $urandom_range(3) == 0) v = v + 16'($urandom_range(7));
         send_word(op, v, lab, e == n - 1);
      end
   endtask

   task automatic random_traffic(int words);
      int r, start_words;
      start_words = 0;
      while (start_words < words) begin
         r = $urandom_range(99);
         if (r < 35) send_vector(nvs_pkg::OP_ADD, vec_len, 16'($urandom));
         else if (r < 45 && n_entries > 0)
            send_vector(nvs_pkg::OP_ADD, vec_len, 16'($urandom),
                        $urandom_range(n_entries - 1));
         else if (r < 65) send_vector(nvs_pkg::OP_QUERY, vec_len, 16'($urandom));
         else if (r < 75 && n_entries > 0)
            send_vector(nvs_pkg::OP_QUERY, vec_len, 16'($urandom),
                        $urandom_range(n_entries - 1));
         else if (r < 82)
            send_vector($urandom_range(1) ? nvs_pkg::OP_ADD : nvs_pkg::OP_QUERY,
                        vec_len + ($urandom_range(1) ? 1 : -1), 16'($urandom));
         else if (r < 88) begin
            // mixed word ops, closed by a query
            for (int e = 0; e < vec_len - 1; e++)
               send_word($urandom_range(1) ? nvs_pkg::OP_ADD : nvs_pkg::OP_QUERY,
                         rand_elem(), 16'($urandom), 1'b0);
            send_word(nvs_pkg::OP_QUERY, rand_elem(), 16'($urandom), 1'b1);
         end else if (r < 92)
            send_word(nvs_pkg::OP_NONE, rand_elem(), 16'($urandom), 1'($urandom_range(1)));
         else if (r < 95)
            send_word(nvs_pkg::OP_BUILD, rand_elem(), 16'($urandom), 1'($urandom_range(1)));
         else begin
            // mixed word ops closed by an add of the wrong length
            send_word(nvs_pkg::OP_QUERY, rand_elem(), 16'($urandom), 1'b0);
            for (int e = 0; e < vec_len; e++)
               send_word(nvs_pkg::OP_ADD, rand_elem(), 16'($urandom), e == vec_len - 1);
         end
         start_words += vec_len;
      end
   endtask

   task automatic new_setting(int pct, logic [7:0] len, logic [7:0] k);
      idle_pct = pct;
      write_reg(nvs_pkg::CSR_VECTOR_LENGTH, len);
      write_reg(nvs_pkg::CSR_TOP_K, k);
      send_word(nvs_pkg::OP_BUILD, 16'h0, 16'h0, 1'b0);
   endtask

   always @(posedge clock) begin
      match_word_type w;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
      if (!reset && rsp_valid) begin
         if (expected_matches.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word: status %0d label %h",
                                           rsp_status, rsp_match_label);
         end else begin
            w = expected_matches.pop_front();
            if (rsp_status !== w.status || rsp_rank !== w.rank ||
                rsp_match_label !== w.label || rsp_similarity !== w.sim ||
                rsp_last_result !== w.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp st %0d rank %0d label %h sim %h last %b, ",
                           w.status, w.rank, w.label, w.sim, w.last,
                           "got st %0d rank %0d label %h sim %h last %b",
                           rsp_status, rsp_rank, rsp_match_label, rsp_similarity,
                           rsp_last_result);
            end
         end
      end
   end

   // op, vector length, words, value, label, typed, status, label, similarity
   vector_row_type rows [N_ROWS] = '{
      '{nvs_pkg::OP_QUERY, 128, 1, 16'h0000, 16'h0, 1, nvs_pkg::ST_EMPTY, 16'h0, 16'h0},
      '{nvs_pkg::OP_ADD, 128, 1, 16'h1234, 16'h1, 1, nvs_pkg::ST_EMPTY, 16'h0, 16'h0},
      '{nvs_pkg::OP_BUILD, 128, 1, 16'h0000, 16'h0, 1, nvs_pkg::ST_OK, 16'h0, 16'h0},
      '{nvs_pkg::OP_QUERY, 128, 1, 16'h0000, 16'h0, 1, nvs_pkg::ST_EMPTY, 16'h0, 16'h0},
      '{nvs_pkg::OP_ADD, 128, 1, 16'h7fff, 16'h2, 1, nvs_pkg::ST_DIM_ERR, 16'h0, 16'h0},
      '{nvs_pkg::OP_ADD, 2, 2, 16'h8000, 16'hffff, 1, nvs_pkg::ST_OK, 16'h0, 16'h0},
      '{nvs_pkg::OP_ADD, 2, 1, 16'h7fff, 16'h0002, 1, nvs_pkg::ST_DIM_ERR, 16'h0, 16'h0},
      '{nvs_pkg::OP_ADD, 2, 5, 16'h7fff, 16'h0003, 1, nvs_pkg::ST_DIM_ERR, 16'h0, 16'h0},
      '{nvs_pkg::OP_QUERY, 2, 2, 16'h7fff, 16'h0, 1, nvs_pkg::ST_OK, 16'hffff, 16'h0000},
      '{nvs_pkg::OP_QUERY, 2, 2, 16'h8000, 16'h0, 1, nvs_pkg::ST_OK, 16'hffff, 16'h8000},
      '{nvs_pkg::OP_NONE, 2, 1, 16'hffff, 16'hffff, 0, nvs_pkg::ST_OK, 16'h0, 16'h0},
      '{nvs_pkg::OP_QUERY, 2, 3, 16'h0001, 16'h0, 1, nvs_pkg::ST_DIM_ERR, 16'h0, 16'h0},
      '{nvs_pkg::OP_ADD, 2, 2, 16'h0000, 16'h0000, 1, nvs_pkg::ST_OK, 16'h0, 16'h0},
      '{nvs_pkg::OP_ADD, 2, 2, 16'h0000, 16'h00aa, 1, nvs_pkg::ST_OK, 16'h0, 16'h0},
      '{nvs_pkg::OP_QUERY, 2, 2, 16'h0000, 16'h0, 1, nvs_pkg::ST_OK, 16'h0000, 16'h8000},
      '{nvs_pkg::OP_QUERY, 2, 2, 16'h0100, 16'h0, 0, nvs_pkg::ST_OK, 16'h0, 16'h0}
   };

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      foreach (rows[i]) begin
         if (rows[i].len != vec_len)
            write_reg(nvs_pkg::CSR_VECTOR_LENGTH, 8'(rows[i].len));
         for (int e = 0; e < rows[i].count; e++)
            send_word(rows[i].op, rows[i].value, rows[i].label, e == rows[i].count - 1,
                      rows[i].typed,
                      '{rows[i].status, 3'd0, rows[i].exp_label, rows[i].exp_sim, 1'b1});
      end
      write_reg(nvs_pkg::CSR_TOP_K, 8'd8);
      send_vector(nvs_pkg::OP_QUERY, 2, 16'h0);
      send_vector(nvs_pkg::OP_ADD, 2, 16'h5a5a);
      send_vector(nvs_pkg::OP_QUERY, 2, 16'h0);

      // lengths that never fit
      new_setting(0, 8'd0, 8'd0);
      send_vector(nvs_pkg::OP_ADD, 1, 16'h1);
      send_vector(nvs_pkg::OP_QUERY, 1, 16'h1);
      new_setting(21, 8'd255, 8'd3);
      send_vector(nvs_pkg::OP_ADD, 2, 16'h1);
      send_vector(nvs_pkg::OP_QUERY, 2, 16'h1);

      new_setting(0, 8'd3, 8'd2);
      random_traffic(15);
      new_setting(81, 8'd2, 8'd8);
      random_traffic(12);
      new_setting(21, 8'd1, 8'd0);
      random_traffic(8);
      new_setting(0, 8'd4, 8'd5);
      random_traffic(16);
      new_setting(81, 8'd6, 8'd15);
      random_traffic(18);

      quiesce();
      repeat (50) @(posedge clock);
      if (mismatches == 0 && expected_matches.size() == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule
